// ===== hw/rtl/cftm_pkg.sv =====
// Shared types and codes for the CAN frame traffic monitor.
`default_nettype none
package cftm_pkg;

    localparam logic [1:0] FUNC_ACCOUNT = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    localparam logic [2:0] ST_KNOWN      = 3'd0;
    localparam logic [2:0] ST_NEW        = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_READ_OK    = 3'd3;
    localparam logic [2:0] ST_READ_EMPTY = 3'd4;
    localparam logic [2:0] ST_CLEARED    = 3'd5;

    localparam logic [3:0] MAX_LEN = 4'd8;

    typedef struct packed {
        logic [1:0]  func;
        logic [28:0] frame_id;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  length_code;
        logic [63:0] payload;
        logic [63:0] time_us;
        logic [4:0]  look_back;
    } t_in;

    typedef struct packed {
        logic [2:0]  match_status;
        logic [3:0]  slot;
        logic [31:0] id_frame_count;
        logic [31:0] total_frames;
        logic [31:0] overflow_count;
        logic [31:0] length_bin_count;
        logic [28:0] ring_ident;
        logic        ring_extended;
        logic        ring_remote;
        logic [3:0]  ring_length;
        logic [63:0] ring_payload;
        logic [63:0] ring_time;
    } t_out;

    typedef struct packed {
        logic take;
        logic look;
        logic next;
        logic hit;
        logic miss;
        logic rrd;
        logic rwr;
        logic rda;
        logic rdb;
        logic sweep;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic key_hit;
        logic sweep_last;
    } t_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/can_frame_traffic_monitor.sv =====
// Top level of the CAN frame traffic monitor.
// One transaction in, one result out (func 3 is consumed with no result).
// The identifier table (key and count memories) is scanned one slot at a time,
// each slot passing a look state and a compare state. A hit ends the scan at
// its slot; a new or overflowing identifier walks every used slot. A ring
// read passes states S_RDA and S_RDB. A clear sweeps the ring payload memory
// one entry per cycle; the same sweep, with no result, also runs after reset.
// No input transaction is taken during a sweep. A finished result sits in an
// output register, so the next transaction is taken while the result waits
// for o_out_valid to be acknowledged; a later result that is ready while the
// earlier one still waits holds the block until the earlier one is taken.
`default_nettype none
module can_frame_traffic_monitor #(
    parameter int ID_SLOTS   = 16,
    parameter int RING_DEPTH = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire cftm_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output cftm_pkg::t_out      o_out
);
    import cftm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // controller: sequences scan, ring update, read and clear sweep
    cftm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in.func),
        .i_out_ready(i_out_ready),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .o_cmd      (cmd)
    );

    // datapath: counters, table and ring memories, result registers
    cftm_dp #(
        .ID_SLOTS  (ID_SLOTS),
        .RING_DEPTH(RING_DEPTH)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_out  (o_out)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/cftm_ctrl.sv =====
// Sequencing state machine of the traffic monitor.
`default_nettype none
module cftm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic [1:0]     i_func,
    input  wire logic           i_out_ready,
    input  wire cftm_pkg::t_stat i_stat,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output cftm_pkg::t_cmd      o_cmd
);
    import cftm_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_LOOK  = 9'b000000100,
        S_CMP   = 9'b000001000,
        S_RRD   = 9'b000010000,
        S_RWR   = 9'b000100000,
        S_RDA   = 9'b001000000,
        S_RDB   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_report, n_report;
    logic   r_out_valid, n_out_valid;
    logic   take;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign take        = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_report    = r_report;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_cmd.take = 1'b1;
                    unique case (i_func)
                        FUNC_ACCOUNT: n_state = S_LOOK;
                        FUNC_READ:    n_state = S_RDA;
                        FUNC_CLEAR: begin
                            n_state  = S_CLEAR;
                            n_report = 1'b1;
                        end
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = r_report ? S_DONE : S_IDLE;
                end
            end
            S_LOOK: begin
                if (i_stat.scan_end) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_RRD;
                end else begin
                    o_cmd.look = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.key_hit) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_RRD;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_RRD: begin
                o_cmd.rrd = 1'b1;
                n_state   = S_RWR;
            end
            S_RWR: begin
                o_cmd.rwr = 1'b1;
                n_state   = S_DONE;
            end
            S_RDA: begin
                o_cmd.rda = 1'b1;
                n_state   = S_RDB;
            end
            S_RDB: begin
                o_cmd.rdb = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_report    <= n_report;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/cftm_dp.sv =====
// Datapath: counters, identifier table, recent-frame ring, result registers.
`default_nettype none
module cftm_dp #(
    parameter int ID_SLOTS   = 16,
    parameter int RING_DEPTH = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire cftm_pkg::t_in   i_in,
    input  wire cftm_pkg::t_cmd  i_cmd,
    output cftm_pkg::t_stat      o_stat,
    output cftm_pkg::t_out       o_out
);
    import cftm_pkg::*;

    localparam int SW = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
    localparam int UW = $clog2(ID_SLOTS + 1);
    localparam int RW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int TW = RW + 1;

    // statistics
    logic [31:0]   r_total, r_ovf;
    logic [31:0]   r_hist [9];
    logic [UW-1:0] r_used, r_idx;
    logic [RW-1:0] r_wpos, r_sweep;
    logic [FW-1:0] r_fill;
    logic          r_empty;

    t_in           r_item;
    logic [3:0]    r_len;
    t_out          r_res, r_out;
    t_out          take_res;

    // identifier table
    logic [29:0]   r_key_mem [ID_SLOTS];
    logic [31:0]   r_cnt_mem [ID_SLOTS];
    logic [29:0]   r_key_q;
    logic [31:0]   r_cnt_q;

    // ring
    logic [28:0]   r_rid_mem [RING_DEPTH];
    logic [1:0]    r_rfl_mem [RING_DEPTH];
    logic [3:0]    r_rln_mem [RING_DEPTH];
    logic [63:0]   r_rpy_mem [RING_DEPTH];
    logic [63:0]   r_rtm_mem [RING_DEPTH];
    logic [28:0]   r_rid_q;
    logic [1:0]    r_rfl_q;
    logic [3:0]    r_rln_q;
    logic [63:0]   r_rpy_q, r_rtm_q;

    logic [3:0]    len_c;
    logic [31:0]   hist_inc;
    logic [29:0]   key;
    logic          room;
    logic [63:0]   mask, merged;
    logic [TW-1:0] rd_tmp;
    logic [RW-1:0] rd_addr;
    logic          rd_empty;
    logic [RW-1:0] pay_raddr;

    assign len_c    = (i_in.length_code > MAX_LEN) ? MAX_LEN : i_in.length_code;
    assign hist_inc = r_hist[len_c] + 32'd1;
    assign key      = {r_item.is_extended, r_item.frame_id};
    assign room     = (r_used < UW'(ID_SLOTS));

    assign o_stat.scan_end   = (r_idx == r_used);
    assign o_stat.key_hit    = (r_key_q == key);
    assign o_stat.sweep_last = (r_sweep == RW'(RING_DEPTH - 1));
    assign o_out             = r_out;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            mask[b*8 +: 8] = (4'(b) < r_len) ? 8'hFF : 8'h00;
        end
    end
    assign merged = (r_rpy_q & ~mask) | (r_item.payload & mask);

    // newest entry sits one behind the write position
    assign rd_tmp   = TW'(r_wpos) + TW'(RING_DEPTH - 1) - TW'(r_item.look_back);
    assign rd_addr  = (rd_tmp >= TW'(RING_DEPTH)) ? RW'(rd_tmp - TW'(RING_DEPTH))
                                                  : rd_tmp[RW-1:0];
    assign rd_empty = (32'(r_item.look_back) >= 32'(r_fill));
    assign pay_raddr = i_cmd.rrd ? r_wpos : rd_addr;

    // result fields known at acceptance
    always_comb begin
        take_res = '0;
        if (i_in.func == FUNC_ACCOUNT) begin
            take_res.total_frames     = r_total + 32'd1;
            take_res.length_bin_count = hist_inc;
        end else if (i_in.func == FUNC_READ) begin
            take_res.total_frames   = r_total;
            take_res.overflow_count = r_ovf;
        end else begin
            take_res.match_status = ST_CLEARED;
        end
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_ovf   <= '0;
            r_used  <= '0;
            r_idx   <= '0;
            r_wpos  <= '0;
            r_fill  <= '0;
            r_sweep <= '0;
            for (int k = 0; k < 9; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            if (i_cmd.take) begin
                r_idx <= '0;
                if (i_in.func == FUNC_ACCOUNT) begin
                    r_total       <= r_total + 32'd1;
                    r_hist[len_c] <= hist_inc;
                end else if (i_in.func == FUNC_CLEAR) begin
                    r_total <= '0;
                    r_ovf   <= '0;
                    r_used  <= '0;
                    r_wpos  <= '0;
                    r_fill  <= '0;
                    r_sweep <= '0;
                    for (int k = 0; k < 9; k++) begin
                        r_hist[k] <= '0;
                    end
                end
            end
            if (i_cmd.next) begin
                r_idx <= r_idx + UW'(1);
            end
            if (i_cmd.miss) begin
                if (room) begin
                    r_used <= r_used + UW'(1);
                end else begin
                    r_ovf <= r_ovf + 32'd1;
                end
            end
            if (i_cmd.rwr) begin
                r_wpos <= (r_wpos == RW'(RING_DEPTH - 1)) ? '0 : r_wpos + RW'(1);
                if (r_fill < FW'(RING_DEPTH)) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + RW'(1);
            end
        end
    end

    // item capture and result build-up
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_in;
            r_len  <= len_c;
            r_res  <= take_res;
        end
        if (i_cmd.hit) begin
            r_res.match_status   <= ST_KNOWN;
            r_res.slot           <= 4'(32'(r_idx));
            r_res.id_frame_count <= r_cnt_q + 32'd1;
            r_res.overflow_count <= r_ovf;
        end
        if (i_cmd.miss) begin
            if (room) begin
                r_res.match_status   <= ST_NEW;
                r_res.slot           <= 4'(32'(r_used));
                r_res.id_frame_count <= 32'd1;
                r_res.overflow_count <= r_ovf;
            end else begin
                r_res.match_status   <= ST_FULL;
                r_res.overflow_count <= r_ovf + 32'd1;
            end
        end
        if (i_cmd.rda) begin
            r_empty            <= rd_empty;
            r_res.match_status <= rd_empty ? ST_READ_EMPTY : ST_READ_OK;
        end
        if (i_cmd.rdb && !r_empty) begin
            r_res.ring_ident    <= r_rid_q;
            r_res.ring_extended <= r_rfl_q[0];
            r_res.ring_remote   <= r_rfl_q[1];
            r_res.ring_length   <= r_rln_q;
            r_res.ring_payload  <= r_rpy_q;
            r_res.ring_time     <= r_rtm_q;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    // identifier table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_key_q <= r_key_mem[r_idx[SW-1:0]];
            r_cnt_q <= r_cnt_mem[r_idx[SW-1:0]];
        end
        if (i_cmd.hit) begin
            r_cnt_mem[r_idx[SW-1:0]] <= r_cnt_q + 32'd1;
        end else if (i_cmd.miss && room) begin
            r_cnt_mem[r_used[SW-1:0]] <= 32'd1;
        end
        if (i_cmd.miss && room) begin
            r_key_mem[r_used[SW-1:0]] <= key;
        end
    end

    // ring memories; only payload needs clearing, the rest is written before read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rrd || i_cmd.rda) begin
            r_rpy_q <= r_rpy_mem[pay_raddr];
        end
        if (i_cmd.sweep) begin
            r_rpy_mem[r_sweep] <= '0;
        end else if (i_cmd.rwr) begin
            r_rpy_mem[r_wpos] <= merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rda) begin
            r_rid_q <= r_rid_mem[rd_addr];
            r_rfl_q <= r_rfl_mem[rd_addr];
            r_rln_q <= r_rln_mem[rd_addr];
            r_rtm_q <= r_rtm_mem[rd_addr];
        end
        if (i_cmd.rwr) begin
            r_rid_mem[r_wpos] <= r_item.frame_id;
            r_rfl_mem[r_wpos] <= {r_item.is_remote, r_item.is_extended};
            r_rln_mem[r_wpos] <= r_len;
            r_rtm_mem[r_wpos] <= r_item.time_us;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/cftm_checker.sv =====
// Port-level checks for the traffic monitor and their bind.
`default_nettype none
module cftm_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire cftm_pkg::t_out o_out
);
    import cftm_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.match_status == ST_FULL) |->
        (o_out.slot == 4'd0 && o_out.id_frame_count == 32'd0 &&
         o_out.overflow_count != 32'd0))
        else $error("table full result malformed");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.match_status == ST_CLEARED) |->
        (o_out.total_frames == 32'd0 && o_out.overflow_count == 32'd0))
        else $error("clear result not zero");

    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.match_status == ST_NEW) |->
        (o_out.id_frame_count == 32'd1 && o_out.total_frames != 32'd0))
        else $error("new entry count wrong");

endmodule

bind can_frame_traffic_monitor cftm_checker u_cftm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out      (o_out)
);
`default_nettype wire
